[hw/rtl/drs_pkg.sv]
// Shared types and constants for the decimal radix sorter.
package drs_pkg;

  localparam int unsigned VAL_W   = 31;
  localparam int unsigned RADIX   = 10;
  localparam int unsigned DIG_W   = 4;
  localparam int unsigned ENTRY_W = 2 * VAL_W;
  // Reciprocal of ten: floor(q * RECIP10 / 2**RECIP_SH) == q / 10 for any 32-bit q.
  localparam logic [31:0] RECIP10  = 32'hCCCC_CCCD;
  localparam int unsigned RECIP_SH = 35;
  localparam int unsigned PROD_W   = VAL_W + 32;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_CHECK,
    ST_HIST_GO,
    ST_HIST_RUN,
    ST_PREFIX,
    ST_PLACE_GO,
    ST_PLACE_RUN,
    ST_FLIP,
    ST_OUT_RD,
    ST_OUT_LD,
    ST_OUT_WAIT
  } drs_state_t;

  typedef struct packed {
    logic loading;
    logic clear_counts;
    logic start_hist;
    logic start_place;
    logic prefix_step;
    logic flip;
    logic rd_out;
    logic load_out;
    logic next_out;
    logic clear_set;
  } drs_cmd_t;

  typedef struct packed {
    logic sweep_busy;
    logic prefix_last;
    logic lq_zero;
    logic out_done;
    logic out_last;
  } drs_stat_t;

endpackage

[hw/rtl/drs_ram.sv]
// Generic simple dual-port RAM with registered read.
module drs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[hw/rtl/drs_ctrl.sv]
// Sequencer for loading, digit passes and draining of the sorted set.
module drs_ctrl
  import drs_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_last,
  input  drs_stat_t stat,
  output drs_cmd_t  cmd
);

  drs_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD:      if (in_valid && in_last) state_nxt = ST_CHECK;
      ST_CHECK:     state_nxt = stat.lq_zero ? ST_OUT_RD : ST_HIST_GO;
      ST_HIST_GO:   state_nxt = ST_HIST_RUN;
      ST_HIST_RUN:  if (!stat.sweep_busy) state_nxt = ST_PREFIX;
      ST_PREFIX:    if (stat.prefix_last) state_nxt = ST_PLACE_GO;
      ST_PLACE_GO:  state_nxt = ST_PLACE_RUN;
      ST_PLACE_RUN: if (!stat.sweep_busy) state_nxt = ST_FLIP;
      ST_FLIP:      state_nxt = ST_CHECK;
      ST_OUT_RD:    state_nxt = ST_OUT_LD;
      ST_OUT_LD:    state_nxt = ST_OUT_WAIT;
      ST_OUT_WAIT: begin
        if (stat.out_done) begin
          state_nxt = stat.out_last ? ST_LOAD : ST_OUT_RD;
        end
      end
      default:      state_nxt = ST_LOAD;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      ST_LOAD:      cmd.loading = 1'b1;
      ST_CHECK:     cmd.clear_counts = 1'b1;
      ST_HIST_GO:   cmd.start_hist = 1'b1;
      ST_PREFIX:    cmd.prefix_step = 1'b1;
      ST_PLACE_GO:  cmd.start_place = 1'b1;
      ST_FLIP:      cmd.flip = 1'b1;
      ST_OUT_RD:    cmd.rd_out = 1'b1;
      ST_OUT_LD:    cmd.load_out = 1'b1;
      ST_OUT_WAIT: begin
        cmd.next_out  = stat.out_done && !stat.out_last;
        cmd.clear_set = stat.out_done && stat.out_last;
      end
      default:      cmd = '0;
    endcase
  end

endmodule

[hw/rtl/drs_dp.sv]
// Datapath: ping-pong buffers, digit pipeline, digit counters, output register.
module drs_dp
  import drs_pkg::*;
#(
  parameter int unsigned MAX_ELEMENTS = 64,
  localparam int unsigned AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1,
  localparam int unsigned CW = $clog2(MAX_ELEMENTS + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  drs_cmd_t         cmd,
  input  logic             in_valid,
  input  logic [VAL_W-1:0] in_value,
  input  logic             out_stall,
  output drs_stat_t        stat,
  output logic             out_valid,
  output logic [VAL_W-1:0] out_value,
  output logic             out_last,
  output logic             out_overflowed
);

  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ELEMENTS);

  logic [CW-1:0]    count_r;
  logic [VAL_W-1:0] lq_r;
  logic [VAL_W-1:0] lqd_r;
  logic             drop_r;
  logic             sel_r;
  logic [AW-1:0]    idx_r;
  logic             issue_r;
  logic             place_r;
  logic             v1_r, v2_r, v3_r;
  logic [VAL_W-1:0] val2_r, q2_r, val3_r, qd3_r;
  logic [PROD_W-1:0] prod_r;
  logic [DIG_W-1:0] dig3_r;
  logic [DIG_W-1:0] pd_r;
  logic [CW-1:0]    cnt_r [RADIX];
  logic             out_valid_r, out_last_r;
  logic [VAL_W-1:0] out_value_r;

  logic               load_wr, place_wr, rd_en;
  logic [ENTRY_W-1:0] a_rdata, b_rdata, src_rdata, wdata;
  logic [AW-1:0]      waddr, last_idx, pos;
  logic [CW-1:0]      pos_full;
  logic [PROD_W-1:0]  lq_prod;
  logic [VAL_W-1:0]   qd2, qd2x10, rem2;
  logic               out_done;

  assign load_wr   = cmd.loading && in_valid && (count_r < MAX_CNT);
  assign place_wr  = v3_r && place_r;
  assign rd_en     = issue_r || cmd.rd_out;
  assign last_idx  = AW'(count_r - CW'(1));
  assign pos_full  = cnt_r[dig3_r] - CW'(1);
  assign pos       = pos_full[AW-1:0];
  assign waddr     = place_wr ? pos : count_r[AW-1:0];
  assign wdata     = place_wr ? {val3_r, qd3_r} : {in_value, in_value};
  assign src_rdata = sel_r ? b_rdata : a_rdata;

  drs_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_ELEMENTS)) u_ram_a (
    .clk   (clk),
    .we    ((load_wr && !sel_r) || (place_wr && sel_r)),
    .waddr (waddr),
    .wdata (wdata),
    .re    (rd_en),
    .raddr (idx_r),
    .rdata (a_rdata)
  );

  drs_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_ELEMENTS)) u_ram_b (
    .clk   (clk),
    .we    ((load_wr && sel_r) || (place_wr && !sel_r)),
    .waddr (waddr),
    .wdata (wdata),
    .re    (rd_en),
    .raddr (idx_r),
    .rdata (b_rdata)
  );

  // Digit = q mod 10, next quotient = q / 10.
  assign qd2    = VAL_W'(prod_r >> RECIP_SH);
  assign qd2x10 = (qd2 << 3) + (qd2 << 1);
  assign rem2   = q2_r - qd2x10;
  assign lq_prod = PROD_W'(lq_r) * PROD_W'(RECIP10);

  // Pipeline payload
  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(src_rdata[VAL_W-1:0]) * PROD_W'(RECIP10);
    val2_r <= src_rdata[ENTRY_W-1:VAL_W];
    q2_r   <= src_rdata[VAL_W-1:0];
    val3_r <= val2_r;
    qd3_r  <= qd2;
    dig3_r <= rem2[DIG_W-1:0];
    lqd_r  <= VAL_W'(lq_prod >> RECIP_SH);
    if (cmd.load_out) begin
      out_value_r <= src_rdata[ENTRY_W-1:VAL_W];
      out_last_r  <= (idx_r == last_idx);
    end
  end

  assign out_done = out_valid_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      lq_r        <= '0;
      drop_r      <= 1'b0;
      sel_r       <= 1'b0;
      idx_r       <= '0;
      issue_r     <= 1'b0;
      place_r     <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      pd_r        <= DIG_W'(1);
      out_valid_r <= 1'b0;
      for (int d = 0; d < RADIX; d++) cnt_r[d] <= '0;
    end else begin
      v1_r <= issue_r;
      v2_r <= v1_r;
      v3_r <= v2_r;

      if (cmd.loading && in_valid) begin
        if (count_r < MAX_CNT) begin
          count_r <= count_r + CW'(1);
          if (in_value > lq_r) lq_r <= in_value;
        end else begin
          drop_r <= 1'b1;
        end
      end

      if (cmd.clear_counts) begin
        for (int d = 0; d < RADIX; d++) cnt_r[d] <= '0;
        pd_r  <= DIG_W'(1);
        idx_r <= '0;
      end

      // Start a backward sweep over the source buffer
      if (cmd.start_hist || cmd.start_place) begin
        idx_r   <= last_idx;
        issue_r <= 1'b1;
        place_r <= cmd.start_place;
      end else if (issue_r) begin
        if (idx_r == '0) issue_r <= 1'b0;
        else             idx_r   <= idx_r - AW'(1);
      end

      if (v3_r) begin
        if (place_r) cnt_r[dig3_r] <= pos_full;
        else         cnt_r[dig3_r] <= cnt_r[dig3_r] + CW'(1);
      end

      if (cmd.prefix_step) begin
        cnt_r[pd_r] <= cnt_r[pd_r] + cnt_r[pd_r - DIG_W'(1)];
        pd_r        <= pd_r + DIG_W'(1);
      end

      if (cmd.flip) begin
        lq_r  <= lqd_r;
        sel_r <= !sel_r;
      end

      if (cmd.load_out)    out_valid_r <= 1'b1;
      else if (out_done)   out_valid_r <= 1'b0;
      if (cmd.next_out)    idx_r <= idx_r + AW'(1);

      if (cmd.clear_set) begin
        count_r <= '0;
        lq_r    <= '0;
        drop_r  <= 1'b0;
      end
    end
  end

  assign stat.sweep_busy  = issue_r || v1_r || v2_r || v3_r;
  assign stat.prefix_last = (pd_r == DIG_W'(RADIX - 1));
  assign stat.lq_zero     = (lq_r == '0);
  assign stat.out_done    = out_done;
  assign stat.out_last    = out_last_r;

  assign out_valid      = out_valid_r;
  assign out_value      = out_value_r;
  assign out_last       = out_last_r;
  assign out_overflowed = drop_r;

endmodule

[hw/rtl/decimal_radix_sorter.sv]
// Values are loaded one per cycle; after the last one, one pass per decimal digit of
// the largest value (at most ten passes), then the sorted requests go out one at a time.
// One set at a time: no new set is taken until the last sorted request of the set is out.
// The pass time is set by two sweeps of one buffer read port per cycle plus a 9-step prefix sum.
// Reset (synchronous, rst_n low) clears controller, count, largest value, drop flag, counters and valid flags.
module decimal_radix_sorter
  import drs_pkg::*;
#(
  parameter int unsigned MAX_ELEMENTS = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  // Input request channel
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [VAL_W-1:0] in_value_in,
  input  logic             in_last_in,
  // Result request channel
  output logic             out_valid,
  input  logic             out_stall,
  output logic [VAL_W-1:0] out_value_out,
  output logic             out_last_out,
  output logic             out_overflowed
);

  drs_cmd_t  cmd;
  drs_stat_t stat;

  // Accept requests only while loading; hold off during sort and drain.
  assign in_stall = !cmd.loading;

  // Sequencer: load, digit passes (histogram, prefix, place, swap buffers), drain.
  drs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_last  (in_last_in),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Datapath: each buffer entry carries the value and its running quotient by
  // the place value, so each pass only needs a constant divide by ten.
  // The element buffers are not cleared; only written entries are ever read.
  drs_dp #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_valid       (in_valid),
    .in_value       (in_value_in),
    .out_stall      (out_stall),
    .stat           (stat),
    .out_valid      (out_valid),
    .out_value      (out_value_out),
    .out_last       (out_last_out),
    .out_overflowed (out_overflowed)
  );

endmodule

[verif/tb.sv]
// Self-checking testbench for the decimal radix sorter: random sets, sorted and compared.
module tb
  import drs_pkg::*;
();

  localparam int unsigned CAP = 64;

  // One input request and one sorted result request.
  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic             last;
  } load_req_t;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic             last;
    logic             dropped;
  } sorted_req_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [VAL_W-1:0] in_value_in = '0;
  logic             in_last_in = 1'b0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [VAL_W-1:0] out_value_out;
  logic             out_last_out;
  logic             out_overflowed;

  decimal_radix_sorter #(.MAX_ELEMENTS(CAP)) dut (.*);

  always #5 clk = ~clk;

  // Predictor state: the set being gathered and the flags that go with it.
  logic [VAL_W-1:0] set_vals[CAP];
  int unsigned      set_len = 0;
  logic [VAL_W-1:0] set_max = '0;
  logic             set_dropped = 1'b0;

  load_req_t   pending_q[$];
  sorted_req_t sorted_q[$];
  int unsigned mismatches = 0;
  int unsigned fill_hold = 0;   // cycles the receiver is forced to stall
  int unsigned send_pct = 100;  // chance in percent that the sender offers
  int unsigned take_pct = 100;  // chance in percent that the receiver accepts

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("MISMATCH %s: got %0d want %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // One stable counting pass on the decimal digit at weight pv.
  function automatic void digit_sort_pass(input longint unsigned pv);
    int unsigned      tally[10];
    logic [VAL_W-1:0] placed[CAP];
    int unsigned      dg;
    for (int d = 0; d < 10; d++) tally[d] = 0;
    for (int i = 0; i < set_len; i++) tally[(set_vals[i] / pv) % 10]++;
    for (int d = 1; d < 10; d++) tally[d] += tally[d-1];
    for (int i = set_len; i > 0; i--) begin
      dg = 32'((set_vals[i-1] / pv) % 10);
      tally[dg]--;
      placed[tally[dg]] = set_vals[i-1];
    end
    for (int i = 0; i < set_len; i++) set_vals[i] = placed[i];
  endfunction

  // Add one value to the set; on the last one, sort and queue the results.
  function automatic void predict_sorted(input load_req_t r);
    longint unsigned pv;
    sorted_req_t     s;
    if (set_len < CAP) begin
      set_vals[set_len] = r.value;
      set_len++;
      if (r.value > set_max) set_max = r.value;
    end else begin
      set_dropped = 1'b1;
    end
    if (!r.last) return;
    pv = 1;
    for (int p = 0; p < 10; p++) begin
      if (set_max / pv == 0) break;
      digit_sort_pass(pv);
      pv = pv * 10;
    end
    for (int i = 0; i < set_len; i++) begin
      s.value = set_vals[i];
      s.last = (i + 1 == set_len);
      s.dropped = set_dropped;
      sorted_q.push_back(s);
    end
    set_len = 0;
    set_max = '0;
    set_dropped = 1'b0;
  endfunction

  // Driver: advance on acceptance, change inputs on the falling edge only.
  logic accepted_in;
  always @(posedge clk) accepted_in <= rst_n && in_valid && !in_stall;

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || accepted_in) begin
      if (accepted_in) void'(pending_q.pop_front());
      if (pending_q.size() > 0 && $urandom_range(99) < send_pct) begin
        in_valid    <= 1'b1;
        in_value_in <= pending_q[0].value;
        in_last_in  <= pending_q[0].last;
      end else begin
        in_valid <= 1'b0;
      end
    end
    // hold the stalled request unchanged
  end

  // Receiver stall, including the long hold-off that fills the block.
  always @(negedge clk) begin
    if (fill_hold > 0) begin
      fill_hold <= fill_hold - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) >= take_pct);
    end
  end

  // Monitor: predict on accepted input, check on accepted output.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall)
      predict_sorted('{value: in_value_in, last: in_last_in});
    if (rst_n && out_valid && !out_stall) begin
      if (sorted_q.size() == 0) begin
        report_mismatch("unexpected result value", 64'(out_value_out), 64'(0));
      end else begin
        if (out_value_out !== sorted_q[0].value)
          report_mismatch("value_out", 64'(out_value_out), 64'(sorted_q[0].value));
        if (out_last_out !== sorted_q[0].last)
          report_mismatch("last_out", 64'(out_last_out), 64'(sorted_q[0].last));
        if (out_overflowed !== sorted_q[0].dropped)
          report_mismatch("overflowed", 64'(out_overflowed), 64'(sorted_q[0].dropped));
        void'(sorted_q.pop_front());
      end
    end
  end

  function automatic logic [VAL_W-1:0] rand_value();
    case ($urandom_range(4))
      0: rand_value = VAL_W'($urandom_range(9));
      1: rand_value = VAL_W'($urandom_range(999));
      2: rand_value = VAL_W'($urandom);
      3: rand_value = VAL_W'($urandom_range(2)) * 31'd1000000000;
      default: rand_value = VAL_W'($urandom_range(99999));
    endcase
  endfunction

  task automatic queue_set(input int unsigned n);
    for (int i = 0; i < n; i++)
      pending_q.push_back('{value: rand_value(), last: (i == n - 1)});
  endtask

  // Wait until every queued request went in and every result came out.
  task automatic drain();
    while (pending_q.size() > 0 || in_valid || sorted_q.size() > 0) @(posedge clk);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed sets: single element, zeros, extremes, ten-digit values, stability.
    pending_q.push_back('{value: 31'h7FFF_FFFF, last: 1'b1});
    pending_q.push_back('{value: 31'd0, last: 1'b0});
    pending_q.push_back('{value: 31'd0, last: 1'b1});
    pending_q.push_back('{value: 31'h7FFF_FFFF, last: 1'b0});
    pending_q.push_back('{value: 31'd1000000000, last: 1'b0});
    pending_q.push_back('{value: 31'd0, last: 1'b0});
    pending_q.push_back('{value: 31'h5555_5555, last: 1'b0});
    pending_q.push_back('{value: 31'h2AAA_AAAA, last: 1'b0});
    pending_q.push_back('{value: 31'd9, last: 1'b0});
    pending_q.push_back('{value: 31'd10, last: 1'b0});
    pending_q.push_back('{value: 31'd9, last: 1'b1});
    drain();

    // Overflow: a full set plus dropped extras, last one dropped too.
    for (int i = 0; i < CAP + 3; i++)
      pending_q.push_back('{value: rand_value(), last: (i == CAP + 2)});
    // Long receiver hold-off while the sender keeps offering the next set.
    fill_hold = 1500;
    queue_set(10);
    drain();

    // Random phases: no idling, sender idle, receiver stalling, both.
    for (int ph = 0; ph < 4; ph++) begin
      send_pct = (ph == 1 || ph == 3) ? 15 : 100;
      take_pct = (ph == 2 || ph == 3) ? 15 : 100;
      repeat (3) begin
        queue_set($urandom_range(1, 10));
        if ($urandom_range(3) == 0) drain();  // sender pauses until all is out
      end
      drain();
    end
    repeat (100) @(posedge clk);
    if (mismatches == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #20000000;
    $display("end of test: mismatches");
    $finish;
  end
endmodule

[files.f]
hw/rtl/drs_pkg.sv
hw/rtl/drs_ram.sv
hw/rtl/drs_ctrl.sv
hw/rtl/drs_dp.sv
hw/rtl/decimal_radix_sorter.sv
verif/tb.sv
